// ----- rtl/lpfd_pkg.sv -----
// Package for the length-prefixed frame deframer.
// Holds the result type, status and cause codes, and reset constants.
// No dependencies.
package lpfd_pkg;

	localparam int unsigned HDR_BYTES = 8;
	localparam logic [7:0]  MAGIC_RST = 8'd88;
	localparam logic [31:0] MAX_LEN_RST = 32'(10 * 1024 * 1024);
	localparam logic [31:0] HDR_LEN = 32'(HDR_BYTES);

	typedef enum logic [1:0] {
		ST_HDR_BYTE = 2'd0,
		ST_HDR_DONE = 2'd1,
		ST_BODY     = 2'd2,
		ST_ERROR    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CAUSE_NONE   = 2'd0,
		CAUSE_MAGIC  = 2'd1,
		CAUSE_LENGTH = 2'd2,
		CAUSE_RSVD   = 2'd3
	} cause_t;

	typedef enum logic {
		REG_MAGIC   = 1'b0,
		REG_MAX_LEN = 1'b1
	} reg_idx_t;

	typedef struct packed {
		status_t     status;
		cause_t      cause;
		logic [7:0]  body_byte;
		logic [7:0]  version;
		logic [15:0] service;
		logic [31:0] frame_length;
		logic        frame_end;
	} res_t;

endpackage

// ----- rtl/length_prefixed_frame_deframer_top.sv -----
// Each result is registered in the output register, or in the skid register while the output stalls.
// Throughput: one byte per cycle while the skid register is empty; the skid stage holds
// one extra result so the input side stays ready while one result waits downstream.
// Reset: arst_n clears phase, header registers and output valid, and
// loads magic_value 88 and max_frame_length 10485760.
// Top level; uses lpfd_pkg, lpfd_core and lpfd_skid.
module length_prefixed_frame_deframer_top
	import lpfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// error_cause, body_byte, version, service, frame_length, zero pad
	output logic [71:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,  // status
	output logic        m_axis_tlast   // frame_end
);

	res_t core_res;
	res_t out_res;
	logic in_fire;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	lpfd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_fire   (in_fire),
		.in_byte   (s_axis_tdata),
		.res       (core_res)
	);

	lpfd_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_res    (core_res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {6'd0, out_res.frame_length, out_res.service, out_res.version,
		out_res.body_byte, out_res.cause};
	assign m_axis_tuser = out_res.status;
	assign m_axis_tlast = out_res.frame_end;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output register");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |->
		(m_axis_tuser == ST_HDR_DONE || m_axis_tuser == ST_BODY))
		else $error("frame end on a result that cannot close a frame");

	a_err_cause: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_ERROR |->
		(m_axis_tdata[1:0] == CAUSE_MAGIC || m_axis_tdata[1:0] == CAUSE_LENGTH))
		else $error("error status without a cause");

	a_ok_cause: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_ERROR |-> m_axis_tdata[1:0] == CAUSE_NONE)
		else $error("cause set on a non-error result");

endmodule

// ----- rtl/lpfd_core.sv -----
// Deframer state and per-byte result logic.
// Holds configuration registers, header registers and the frame phase.
// Depends on lpfd_pkg.
module lpfd_core
	import lpfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_fire,
	input  logic [7:0]  in_byte,
	output res_t        res
);

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_BODY    = 2'd1,
		PH_ERR_MAG = 2'd2,
		PH_ERR_LEN = 2'd3
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [2:0]  hdr_idx_q, hdr_idx_d;
	logic [7:0]  version_q, version_d;
	logic [7:0]  magic_seen_q, magic_seen_d;
	logic [15:0] service_q, service_d;
	logic [31:0] length_q, length_d;
	logic [31:0] remain_q, remain_d;
	logic [7:0]  magic_cfg_q;
	logic [31:0] max_len_q;
	logic [31:0] body_len;

	assign body_len = length_d - HDR_LEN;

	always_comb begin
		phase_d      = phase_q;
		hdr_idx_d    = hdr_idx_q;
		version_d    = version_q;
		magic_seen_d = magic_seen_q;
		service_d    = service_q;
		length_d     = length_q;
		remain_d     = remain_q;
		res.status    = ST_HDR_BYTE;
		res.cause     = CAUSE_NONE;
		res.body_byte = 8'd0;
		res.frame_end = 1'b0;
		unique case (phase_q)
			PH_ERR_MAG: begin
				res.status = ST_ERROR;
				res.cause  = CAUSE_MAGIC;
			end
			PH_ERR_LEN: begin
				res.status = ST_ERROR;
				res.cause  = CAUSE_LENGTH;
			end
			PH_BODY: begin
				res.status    = ST_BODY;
				res.body_byte = in_byte;
				if (remain_q <= 32'd1) begin
					res.frame_end = 1'b1;
					remain_d      = '0;
					phase_d       = PH_HEADER;
					hdr_idx_d     = '0;
				end else begin
					remain_d = remain_q - 32'd1;
				end
			end
			PH_HEADER: begin
				unique case (hdr_idx_q)
					3'd0: version_d = in_byte;
					3'd1: magic_seen_d = in_byte;
					3'd2: service_d = {in_byte, 8'd0};
					3'd3: service_d = {service_q[15:8], in_byte};
					3'd4: length_d = {in_byte, 24'd0};
					3'd5: length_d = {length_q[31:24], in_byte, 16'd0};
					3'd6: length_d = {length_q[31:16], in_byte, 8'd0};
					3'd7: length_d = {length_q[31:8], in_byte};
					default: length_d = length_q;
				endcase
				hdr_idx_d = hdr_idx_q + 3'd1;
				if (hdr_idx_q == 3'd7) begin
					priority if (magic_seen_q != magic_cfg_q) begin
						phase_d   = PH_ERR_MAG;
						res.status = ST_ERROR;
						res.cause  = CAUSE_MAGIC;
					end else if (length_d < HDR_LEN || length_d > max_len_q) begin
						phase_d   = PH_ERR_LEN;
						res.status = ST_ERROR;
						res.cause  = CAUSE_LENGTH;
					end else begin
						res.status = ST_HDR_DONE;
						remain_d   = body_len;
						if (body_len == 32'd0) begin
							res.frame_end = 1'b1;
						end else begin
							phase_d = PH_BODY;
						end
					end
				end
			end
			default: phase_d = phase_q;
		endcase
		res.version      = version_d;
		res.service      = service_d;
		res.frame_length = length_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_cfg_q <= MAGIC_RST;
			max_len_q   <= MAX_LEN_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MAGIC:   magic_cfg_q <= cfg_data[7:0];
				REG_MAX_LEN: max_len_q <= cfg_data;
				default:     max_len_q <= max_len_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			hdr_idx_q    <= '0;
			version_q    <= '0;
			magic_seen_q <= '0;
			service_q    <= '0;
			length_q     <= '0;
			remain_q     <= '0;
		end else if (in_fire) begin
			phase_q      <= phase_d;
			hdr_idx_q    <= hdr_idx_d;
			version_q    <= version_d;
			magic_seen_q <= magic_seen_d;
			service_q    <= service_d;
			length_q     <= length_d;
			remain_q     <= remain_d;
		end
	end

endmodule

// ----- rtl/lpfd_skid.sv -----
// Output register with a skid stage for deframer results.
// Keeps the input side ready while one result waits downstream.
// Depends on lpfd_pkg.
module lpfd_skid
	import lpfd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  res_t in_res,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_res_q;
	res_t skid_res_q;

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_res_q <= skid_valid_q ? skid_res_q : in_res;
		end else if (in_valid && !skid_valid_q) begin
			skid_res_q <= in_res;
		end
	end

endmodule

// ----- tb/tb.sv -----
// Testbench for length_prefixed_frame_deframer_top: drives byte streams of frames,
// predicts every result with its own deframer model and checks each output transfer.
// Depends on lpfd_pkg and the RTL below length_prefixed_frame_deframer_top.
module tb;
	import lpfd_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	typedef enum logic [1:0] {
		PH_HEADER    = 2'd0,
		PH_BODY      = 2'd1,
		PH_ERR_MAGIC = 2'd2,
		PH_ERR_LEN   = 2'd3
	} deframe_phase_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;  // data_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// error_cause, body_byte, version, service, frame_length, zero pad
	logic [71:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;  // status
	logic        m_axis_tlast;  // frame_end

	// deframer model state and register copies
	logic [7:0]     mdl_magic;
	logic [31:0]    mdl_max_len;
	deframe_phase_t mdl_phase;
	logic [2:0]     mdl_hdr_idx;
	logic [7:0]     mdl_version;
	logic [7:0]     mdl_magic_seen;
	logic [15:0]    mdl_service;
	logic [31:0]    mdl_length;
	logic [31:0]    mdl_remaining;

	res_t expected_results[$];
	int   failures;
	int   quiet_cycles;
	bit   send_gaps;
	bit   recv_stalls;

	length_prefixed_frame_deframer_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic res_t deframe_byte(input logic [7:0] b);
		res_t r;
		r = '0;
		case (mdl_phase)
			PH_ERR_MAGIC, PH_ERR_LEN: begin
				r.status = ST_ERROR;
				r.cause  = (mdl_phase == PH_ERR_MAGIC) ? CAUSE_MAGIC : CAUSE_LENGTH;
			end
			PH_BODY: begin
				r.status    = ST_BODY;
				r.body_byte = b;
				r.frame_end = (mdl_remaining <= 32'd1);
				if (mdl_remaining > 32'd0)
					mdl_remaining = mdl_remaining - 32'd1;
				if (r.frame_end) begin
					mdl_remaining = '0;
					mdl_phase     = PH_HEADER;
					mdl_hdr_idx   = '0;
				end
			end
			default: begin
				case (mdl_hdr_idx)
					3'd0: mdl_version = b;
					3'd1: mdl_magic_seen = b;
					3'd2: mdl_service = {b, 8'h00};
					3'd3: mdl_service[7:0] = b;
					3'd4: mdl_length = {b, 24'h0};
					3'd5: mdl_length[23:16] = b;
					3'd6: mdl_length[15:8] = b;
					default: mdl_length[7:0] = b;
				endcase
				if (mdl_hdr_idx != 3'd7) begin
					mdl_hdr_idx = mdl_hdr_idx + 3'd1;
					r.status    = ST_HDR_BYTE;
				end else begin
					mdl_hdr_idx = '0;
					if (mdl_magic_seen != mdl_magic) begin
						mdl_phase = PH_ERR_MAGIC;
						r.status  = ST_ERROR;
						r.cause   = CAUSE_MAGIC;
					end else if (mdl_length < HDR_LEN || mdl_length > mdl_max_len) begin
						mdl_phase = PH_ERR_LEN;
						r.status  = ST_ERROR;
						r.cause   = CAUSE_LENGTH;
					end else begin
						mdl_remaining = mdl_length - HDR_LEN;
						r.status      = ST_HDR_DONE;
						if (mdl_remaining == 32'd0) begin
							mdl_phase   = PH_HEADER;
							r.frame_end = 1'b1;
						end else begin
							mdl_phase = PH_BODY;
						end
					end
				end
			end
		endcase
		r.version      = mdl_version;
		r.service      = mdl_service;
		r.frame_length = mdl_length;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			failures++;
		end
	endtask

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = send_gaps ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_results.insert(expected_results.size(), deframe_byte(b));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == REG_MAGIC)
			mdl_magic = val[7:0];
		else
			mdl_max_len = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_header(input logic [7:0] ver, input logic [7:0] mag,
			input logic [15:0] svc, input logic [31:0] len);
		send_byte(ver);
		send_byte(mag);
		send_byte(svc[15:8]);
		send_byte(svc[7:0]);
		send_byte(len[31:24]);
		send_byte(len[23:16]);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
	endtask

	task automatic send_random_frame();
		longint top;
		longint len;
		int     pick;
		send_gaps   = ($urandom_range(0, 3) != 0);
		recv_stalls = ($urandom_range(0, 3) != 0);
		top  = (mdl_max_len > 32'd72) ? 72 : longint'(mdl_max_len);
		pick = $urandom_range(0, 9);
		if (pick == 0)
			len = top;
		else if (pick <= 6)
			len = 8 + $urandom_range(0, ((top - 8) > 16) ? 16 : int'(top - 8));
		else
			len = 8 + $urandom_range(0, int'(top - 8));
		send_header(8'($urandom_range(0, 255)), mdl_magic, 16'($urandom_range(0, 65535)),
			32'(len));
		repeat (int'(len - 8)) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic test_directed();
		// empty-body frame, then a frame with extreme header and body bytes
		send_header(8'h00, MAGIC_RST, 16'h0000, 32'd8);
		send_header(8'hFF, MAGIC_RST, 16'hFFFF, 32'd10);
		send_byte(8'h00);
		send_byte(8'hFF);
	endtask

	task automatic test_register_sweep();
		int sent;
		for (int setting = 0; setting < 6; setting++) begin
			case (setting)
				0: begin
					write_reg(REG_MAGIC, 32'd255);
					write_reg(REG_MAX_LEN, 32'hFFFF_FFFF);
				end
				1: begin
					write_reg(REG_MAGIC, 32'd0);
					write_reg(REG_MAX_LEN, 32'd8);
				end
				2: begin
					write_reg(REG_MAGIC, $urandom_range(0, 255));
					write_reg(REG_MAX_LEN, 32'd9);
				end
				default: begin
					write_reg(REG_MAGIC, $urandom_range(0, 255));
					write_reg(REG_MAX_LEN, $urandom_range(8, 80));
				end
			endcase
			sent = 0;
			while (sent < 200) begin
				send_random_frame();
				sent = sent + 8 + int'(mdl_length - 8);
			end
		end
	endtask

	task automatic test_sticky_error();
		int          kind;
		logic [7:0]  mag;
		logic [31:0] len;
		write_reg(REG_MAGIC, $urandom_range(0, 255));
		write_reg(REG_MAX_LEN, $urandom_range(8, 40));
		send_random_frame();
		kind = $urandom_range(0, 3);
		mag  = (kind == 0 || kind == 3) ? (mdl_magic ^ 8'($urandom_range(1, 255))) : mdl_magic;
		case (kind)
			1:       len = ($urandom_range(0, 1) != 0) ? mdl_max_len + 32'd1
				: $urandom_range(mdl_max_len + 1, 32'hFFFF_FFFF);
			2:       len = $urandom_range(0, 7);
			3:       len = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 7)
				: mdl_max_len + 32'd1;
			default: len = $urandom_range(8, mdl_max_len);
		endcase
		send_header(8'($urandom_range(0, 255)), mag, 16'($urandom_range(0, 65535)), len);
		repeat (24) send_byte(8'($urandom_range(0, 255)));
		// stored cause survives register writes that accept the header magic and any high length
		write_reg(REG_MAGIC, {24'h0, mag});
		write_reg(REG_MAX_LEN, 32'hFFFF_FFFF);
		repeat (16) send_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = 1'b0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		failures      = 0;
		send_gaps     = 1'b1;
		recv_stalls   = 1'b1;
		mdl_magic      = MAGIC_RST;
		mdl_max_len    = MAX_LEN_RST;
		mdl_phase      = PH_HEADER;
		mdl_hdr_idx    = '0;
		mdl_version    = '0;
		mdl_magic_seen = '0;
		mdl_service    = '0;
		mdl_length     = '0;
		mdl_remaining  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_register_sweep();
		test_sticky_error();
		wait_idle();
		repeat (4) @(negedge clk);
		if (failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int   stall;
		res_t want;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = recv_stalls ? $urandom_range(0, 5) : 0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
			if (expected_results.size() == 0) begin
				$error("result transfer with no result expected");
				failures++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", 32'(want.status), 32'(m_axis_tuser));
				check_field("error_cause", 32'(want.cause), 32'(m_axis_tdata[1:0]));
				check_field("body_byte", 32'(want.body_byte), 32'(m_axis_tdata[9:2]));
				check_field("version", 32'(want.version), 32'(m_axis_tdata[17:10]));
				check_field("service", 32'(want.service), 32'(m_axis_tdata[33:18]));
				check_field("frame_length", want.frame_length, m_axis_tdata[65:34]);
				check_field("frame_end", 32'(want.frame_end), 32'(m_axis_tlast));
			end
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial quiet_cycles = 0;

endmodule
